/* src/mf3_pkg.sv */
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 mean filter
// Sizes, beat structs, column and issue types, reciprocal table for the mean.
// ----------------------------------------------------------------------------
`default_nettype none

package mf3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W     = 8;
	localparam int SIZE_W    = 11;
	localparam int ROW_W     = 10;
	localparam int COL_W     = 10;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	// arrival row runs up to height + 1 while the tail is flushed
	localparam int AROW_W    = $clog2(MAX_HEIGHT + 2);
	localparam int SUM_W     = $clog2(9 * 255 + 1);
	localparam int CNT_W     = 4;
	localparam int FRAC_W    = 16;
	localparam int RECIP_W   = FRAC_W + 1;
	localparam int CFG_IDX_W = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

	// command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// ceil(2^16 / d), exact for every sum the window can produce
	localparam logic [RECIP_W-1:0] RECIP_1 = RECIP_W'((2**FRAC_W + 0) / 1);
	localparam logic [RECIP_W-1:0] RECIP_2 = RECIP_W'((2**FRAC_W + 1) / 2);
	localparam logic [RECIP_W-1:0] RECIP_3 = RECIP_W'((2**FRAC_W + 2) / 3);
	localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'((2**FRAC_W + 3) / 4);
	localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((2**FRAC_W + 5) / 6);
	localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((2**FRAC_W + 8) / 9);

	typedef struct packed {
		logic             command;
		logic [PIX_W-1:0] pixel;
	} stream_t;

	typedef struct packed {
		logic [PIX_W-1:0] mean_value;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic             last;
	} result_t;

	// one column of the window, top to bottom
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} col_t;

	// which neighbors of the output pixel lie inside the frame
	typedef struct packed {
		logic up;
		logic down;
		logic left;
		logic right;
	} nbr_mask_t;

	// one arrival handed from the position control to the datapath
	typedef struct packed {
		logic              go;
		logic              emit;
		logic [ADDR_W-1:0] addr;
		logic [PIX_W-1:0]  pixel;
		logic [ROW_W-1:0]  out_row;
		logic [COL_W-1:0]  out_col;
		logic              last;
		nbr_mask_t         mask;
	} issue_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] raw,
		input logic [SIZE_W-1:0] limit);
		logic [SIZE_W-1:0] r;
		if (raw == '0) begin
			r = SIZE_W'(1);
		end else if (raw > limit) begin
			r = limit;
		end else begin
			r = raw;
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] nbr_count(input nbr_mask_t m);
		logic [CNT_W-1:0] nc;
		logic [CNT_W-1:0] nr;
		nc = CNT_W'(1) + CNT_W'(m.left) + CNT_W'(m.right);
		nr = CNT_W'(1) + CNT_W'(m.up) + CNT_W'(m.down);
		return CNT_W'(nc * nr);
	endfunction

	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] m;
		unique case (cnt)
			CNT_W'(1): m = RECIP_1;
			CNT_W'(2): m = RECIP_2;
			CNT_W'(3): m = RECIP_3;
			CNT_W'(4): m = RECIP_4;
			CNT_W'(6): m = RECIP_6;
			CNT_W'(9): m = RECIP_9;
			default:   m = '0;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

/* src/mean_filter_3x3_border_aware.sv */
// ----------------------------------------------------------------------------
// mean_filter_3x3_border_aware: 3x3 box mean over a raster pixel stream
// Two line buffers feed a chain of column cells; the in-frame neighbors of
// each output pixel are summed and divided by their count.
// ----------------------------------------------------------------------------
//
//  channel   handshake                 payload
//  stream    stream_valid/ready        stream_data  {command, pixel}
//  result    result_valid/ready        result_data  {mean_value, row, column, last}
//  cfg       cfg_we                    cfg_index, cfg_wdata (11 bits)
//
//  one stream beat per clock while stream_ready is high; the window position is
//  set by one line-buffer read per beat, so the rate then is one pixel or flush
//  per cycle; a window's result passes stage 1, stage 2 and the result register
//  in a single-row frame the first flush waits for a silent shift
//  reset clears positions and sets a 1024x1024 frame; the line buffers need no
//  clearing, only pixels of the current frame are ever summed
//  a stalled result register holds the pipe only once every stage is full
//
`default_nettype none

module mean_filter_3x3_border_aware (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mf3_pkg::SIZE_W-1:0]    cfg_wdata,
	input  wire logic                          stream_valid,
	output      logic                          stream_ready,
	input  wire mf3_pkg::stream_t              stream_data,
	output      logic                          result_valid,
	input  wire logic                          result_ready,
	output mf3_pkg::result_t                   result_data
);

	mf3_pkg::issue_t issue;

	// stage 1: line-buffer read data arrives, window shifts, neighbors summed
	logic                        valid_s1;
	logic                        emit_s1;
	logic [mf3_pkg::ADDR_W-1:0]  addr_s1;
	logic [mf3_pkg::PIX_W-1:0]   pix_s1;
	logic [mf3_pkg::ROW_W-1:0]   row_s1;
	logic [mf3_pkg::COL_W-1:0]   col_s1;
	logic                        last_s1;
	mf3_pkg::nbr_mask_t          mask_s1;
	// same-column bypass for back-to-back beats in one-pixel-wide frames
	logic                        fwd_s1;
	logic [mf3_pkg::PIX_W-1:0]   fwd_pix_s1;
	logic [mf3_pkg::PIX_W-1:0]   fwd_lb1_s1;

	// stage 2: sum and count of the in-frame neighbors
	logic                        valid_s2;
	logic [mf3_pkg::SUM_W-1:0]   sum_s2;
	logic [mf3_pkg::CNT_W-1:0]   cnt_s2;
	logic [mf3_pkg::ROW_W-1:0]   row_s2;
	logic [mf3_pkg::COL_W-1:0]   col_s2;
	logic                        last_s2;

	// stage 3: result register
	logic                        valid_s3;
	mf3_pkg::result_t            res_s3;

	logic s1_free;
	logic s1_adv;
	logic s2_free;
	logic s2_adv;
	logic out_free;

	logic [mf3_pkg::PIX_W-1:0] lb1_rd;
	logic [mf3_pkg::PIX_W-1:0] lb2_rd;
	logic [mf3_pkg::PIX_W-1:0] lb1_val;
	logic [mf3_pkg::PIX_W-1:0] lb2_val;

	mf3_pkg::col_t col_new;
	mf3_pkg::col_t col_a;
	mf3_pkg::col_t col_b;
	mf3_pkg::col_t win [3];
	logic          col_ok [3];

	logic [mf3_pkg::SUM_W-1:0]               sum_nxt;
	logic [mf3_pkg::SUM_W+mf3_pkg::RECIP_W-1:0] prod;

	// pipeline flow: a stage moves when the next one is empty or moving
	always_comb begin
		out_free = !valid_s3 || result_ready;
		s2_adv   = valid_s2 && out_free;
		s2_free  = !valid_s2 || s2_adv;
		// beats without a result retire in stage 1 after shifting the window
		s1_adv   = valid_s1 && (!emit_s1 || s2_free);
		s1_free  = !valid_s1 || s1_adv;
	end

	mf3_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.stream_valid   (stream_valid),
		.stream_command (stream_data.command),
		.stream_pixel   (stream_data.pixel),
		.s1_free        (s1_free),
		.stream_ready   (stream_ready),
		.issue          (issue)
	);

	// line buffer 1 holds the row above the arriving pixel, buffer 2 the one above that
	mf3_ram #(
		.WIDTH (mf3_pkg::PIX_W),
		.DEPTH (mf3_pkg::MAX_WIDTH)
	) u_lb1 (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (issue.go),
		.raddr (issue.addr),
		.rdata (lb1_rd)
	);

	mf3_ram #(
		.WIDTH (mf3_pkg::PIX_W),
		.DEPTH (mf3_pkg::MAX_WIDTH)
	) u_lb2 (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (addr_s1),
		.wdata (lb1_val),
		.re    (issue.go),
		.raddr (issue.addr),
		.rdata (lb2_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= issue.go;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && issue.go) begin
			emit_s1    <= issue.emit;
			addr_s1    <= issue.addr;
			pix_s1     <= issue.pixel;
			row_s1     <= issue.out_row;
			col_s1     <= issue.out_col;
			last_s1    <= issue.last;
			mask_s1    <= issue.mask;
			// the buffer write of the leaving beat lands on the same edge as this read
			fwd_s1     <= s1_adv && (addr_s1 == issue.addr);
			fwd_pix_s1 <= pix_s1;
			fwd_lb1_s1 <= lb1_val;
		end
	end

	always_comb begin
		lb1_val = fwd_s1 ? fwd_pix_s1 : lb1_rd;
		lb2_val = fwd_s1 ? fwd_lb1_s1 : lb2_rd;
		col_new.top = lb2_val;
		col_new.mid = lb1_val;
		col_new.bot = pix_s1;
	end

	// chain of column cells: newest column enters cell a, moves on to cell b
	mf3_cell u_cell_a (
		.clk     (clk),
		.en      (s1_adv),
		.col_in  (col_new),
		.col_out (col_a)
	);

	mf3_cell u_cell_b (
		.clk     (clk),
		.en      (s1_adv),
		.col_in  (col_a),
		.col_out (col_b)
	);

	// window after the shift: left, center, right columns of the output pixel
	always_comb begin
		win[0]    = col_b;
		win[1]    = col_a;
		win[2]    = col_new;
		col_ok[0] = mask_s1.left;
		col_ok[1] = 1'b1;
		col_ok[2] = mask_s1.right;
		sum_nxt   = '0;
		for (int c = 0; c < 3; c++) begin
			if (col_ok[c]) begin
				if (mask_s1.up) begin
					sum_nxt = sum_nxt + mf3_pkg::SUM_W'(win[c].top);
				end
				sum_nxt = sum_nxt + mf3_pkg::SUM_W'(win[c].mid);
				if (mask_s1.down) begin
					sum_nxt = sum_nxt + mf3_pkg::SUM_W'(win[c].bot);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && emit_s1) begin
			sum_s2  <= sum_nxt;
			cnt_s2  <= mf3_pkg::nbr_count(mask_s1);
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
		end
	end

	// divide by the neighbor count as a multiply by its rounded-up reciprocal
	always_comb begin
		prod = (mf3_pkg::SUM_W + mf3_pkg::RECIP_W)'(sum_s2)
			* (mf3_pkg::SUM_W + mf3_pkg::RECIP_W)'(mf3_pkg::recip(cnt_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (out_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			res_s3.mean_value <= prod[mf3_pkg::FRAC_W +: mf3_pkg::PIX_W];
			res_s3.row        <= row_s2;
			res_s3.column     <= col_s2;
			res_s3.last       <= last_s2;
		end
	end

	assign result_valid = valid_s3;
	assign result_data  = res_s3;

endmodule

`default_nettype wire

/* src/mf3_ram.sv */
// ----------------------------------------------------------------------------
// mf3_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (old data on collision).
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* src/mf3_cell.sv */
// ----------------------------------------------------------------------------
// mf3_cell: one column cell of the sliding window
// Holds a three-pixel column and passes it on to the next cell on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_cell (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire mf3_pkg::col_t col_in,
	output mf3_pkg::col_t      col_out
);

	mf3_pkg::col_t col_q;

	always_ff @(posedge clk) begin
		if (en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

endmodule

`default_nettype wire

/* src/mf3_ctrl.sv */
// ----------------------------------------------------------------------------
// mf3_ctrl: frame size registers and raster position control
// Tracks arrival and output positions, decides which beats shift the window
// and which produce a result, and computes the border mask of each result.
// ----------------------------------------------------------------------------
`default_nettype none

module mf3_ctrl (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [mf3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mf3_pkg::SIZE_W-1:0]       cfg_wdata,
	input  wire logic                             stream_valid,
	input  wire logic                             stream_command,
	input  wire logic [mf3_pkg::PIX_W-1:0]        stream_pixel,
	input  wire logic                             s1_free,
	output      logic                             stream_ready,
	output      mf3_pkg::issue_t                  issue
);

	logic [mf3_pkg::SIZE_W-1:0] width_q;
	logic [mf3_pkg::SIZE_W-1:0] height_q;
	logic [mf3_pkg::AROW_W-1:0] in_row_q;
	logic [mf3_pkg::ADDR_W-1:0] in_col_q;
	logic [mf3_pkg::ROW_W-1:0]  out_row_q;
	logic [mf3_pkg::COL_W-1:0]  out_col_q;

	logic full;
	logic emit_ok;
	logic filler;
	logic take;
	logic is_flush;
	logic arrive;
	logic emit;
	logic in_col_end;
	logic out_col_end;
	logic out_row_end;
	logic out_last;

	always_comb begin
		full        = (mf3_pkg::SIZE_W'(in_row_q) >= height_q);
		// arrival position at least width + 1
		emit_ok     = (in_row_q >= mf3_pkg::AROW_W'(2))
			|| ((in_row_q == mf3_pkg::AROW_W'(1)) && (in_col_q != '0));
		// single-row frame: one silent shift before the first flush result
		filler      = full && !emit_ok;
		stream_ready = s1_free && !filler;
		take        = stream_valid && stream_ready;
		is_flush    = (stream_command == mf3_pkg::CMD_FLUSH);
		// pixels count before the frame is full, flushes only after
		arrive      = (take && (is_flush == full)) || (s1_free && filler);
		emit        = arrive && emit_ok;

		in_col_end  = (in_col_q == mf3_pkg::ADDR_W'(width_q - mf3_pkg::SIZE_W'(1)));
		out_col_end = (out_col_q == mf3_pkg::COL_W'(width_q - mf3_pkg::SIZE_W'(1)));
		out_row_end = (out_row_q == mf3_pkg::ROW_W'(height_q - mf3_pkg::SIZE_W'(1)));
		out_last    = out_col_end && out_row_end;

		issue.go         = arrive;
		issue.emit       = emit;
		issue.addr       = in_col_q;
		issue.pixel      = stream_pixel;
		issue.out_row    = out_row_q;
		issue.out_col    = out_col_q;
		issue.last       = out_last;
		issue.mask.up    = (out_row_q != '0);
		issue.mask.down  = !out_row_end;
		issue.mask.left  = (out_col_q != '0);
		issue.mask.right = !out_col_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= mf3_pkg::SIZE_W'(mf3_pkg::MAX_WIDTH);
			height_q  <= mf3_pkg::SIZE_W'(mf3_pkg::MAX_HEIGHT);
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mf3_pkg::CFG_IMAGE_WIDTH: begin
					width_q <= mf3_pkg::clamp_size(cfg_wdata,
						mf3_pkg::SIZE_W'(mf3_pkg::MAX_WIDTH));
				end
				mf3_pkg::CFG_IMAGE_HEIGHT: begin
					height_q <= mf3_pkg::clamp_size(cfg_wdata,
						mf3_pkg::SIZE_W'(mf3_pkg::MAX_HEIGHT));
				end
			endcase
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else if (emit && out_last) begin
			// frame done, next beat starts a new frame
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else begin
			if (arrive) begin
				if (in_col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + mf3_pkg::AROW_W'(1);
				end else begin
					in_col_q <= in_col_q + mf3_pkg::ADDR_W'(1);
				end
			end
			if (emit) begin
				if (out_col_end) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + mf3_pkg::ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + mf3_pkg::COL_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire
